// ===== hdl/sfe_pkg.sv =====
// Shared constants, types and a saturation helper function for the stereo feedback echo.
`default_nettype none

package sfe_pkg;

    localparam int STORE_DEPTH  = 131072;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int SAMPLE_BITS  = 16;
    localparam int DELAY_W      = 17;
    localparam int FB_W         = 16;
    localparam int WET_W        = 17;
    localparam int FRAC_BITS    = 16;
    localparam int FB_MAX       = 58982;
    localparam int WET_FULL     = 65536;
    localparam int DELAY_RESET  = 24000;
    localparam int RND_HALF     = 2 ** (FRAC_BITS - 1);
    localparam int FBP_W        = SAMPLE_BITS + FB_W + 1;
    localparam int MIX_W        = SAMPLE_BITS + WET_W + 1;
    localparam int ACC_W        = SAMPLE_BITS + 2;
    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    typedef enum logic [1:0] {
        REG_ECHO_ENABLE,
        REG_DELAY_LENGTH,
        REG_FEEDBACK_GAIN,
        REG_WET_MIX
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } t_frame;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(2 ** (SAMPLE_BITS - 1)));

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [SAMPLE_BITS-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[SAMPLE_BITS-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            res = v[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sfe_if.sv =====
// Valid/ready stream interfaces for input and output stereo frames.
`default_nettype none

interface sfe_in_if import sfe_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sfe_out_if import sfe_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/stereo_feedback_echo.sv =====
// Stereo feedback echo: delay stores, feedback write-back, wet/dry mix, output queue.
// A frame passes through stages A, B and C and is then written to the output queue.
// One frame per cycle while queue credit lasts, set by one read/write port per store.
// The feedback path reads the store on acceptance and writes it back from stage A;
// a one-entry forward register covers a read of the entry still being written.
// Reset clears control state; stores read as zero until written (write-position wrap flag).
`default_nettype none

module stereo_feedback_echo import sfe_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    sfe_in_if.sink                  i_frame,
    sfe_out_if.source               o_frame
);

    logic                      r_echo_enable;
    logic [DELAY_W-1:0]        r_delay_length;
    logic [FB_W-1:0]           r_feedback_gain;
    logic [WET_W-1:0]          r_wet_mix;

    logic signed [SAMPLE_BITS-1:0] mem_left  [STORE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] mem_right [STORE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rd_left;
    logic signed [SAMPLE_BITS-1:0] r_rd_right;

    logic [ADDR_W-1:0]         r_wp;
    logic                      r_wrapped;

    logic                          r_a_valid;
    logic signed [SAMPLE_BITS-1:0] r_a_left;
    logic signed [SAMPLE_BITS-1:0] r_a_right;
    logic [ADDR_W-1:0]             r_a_rd;
    logic [ADDR_W-1:0]             r_a_wp;
    logic                          r_a_zero;

    logic                          r_fwd_valid;
    logic [ADDR_W-1:0]             r_fwd_addr;
    logic signed [SAMPLE_BITS-1:0] r_fwd_left;
    logic signed [SAMPLE_BITS-1:0] r_fwd_right;

    logic                          r_b_valid;
    logic signed [SAMPLE_BITS-1:0] r_b_left_in;
    logic signed [SAMPLE_BITS-1:0] r_b_right_in;
    logic signed [SAMPLE_BITS-1:0] r_b_left_dly;
    logic signed [SAMPLE_BITS-1:0] r_b_right_dly;

    logic                    r_c_valid;
    logic signed [MIX_W-1:0] r_c_left_dry;
    logic signed [MIX_W-1:0] r_c_left_wet;
    logic signed [MIX_W-1:0] r_c_right_dry;
    logic signed [MIX_W-1:0] r_c_right_wet;

    t_frame               r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_AW:0]     r_fifo_count;

    logic                 cfg_wr;
    t_reg_idx             cfg_idx;
    logic                 in_fire;
    logic                 out_fire;
    logic [FIFO_AW:0]     credit;

    logic [ADDR_W-1:0]    d_cl;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 rd_zero;

    logic [FB_W-1:0]      fb_cl;
    logic [WET_W-1:0]     wet_cl;
    logic [WET_W-1:0]     wet_eff;
    logic [WET_W-1:0]     dry_eff;

    logic                          a_fwd;
    logic signed [SAMPLE_BITS-1:0] a_left_dly;
    logic signed [SAMPLE_BITS-1:0] a_right_dly;
    logic signed [FBP_W-1:0]       fb_s;
    logic signed [FBP_W-1:0]       l_fbp;
    logic signed [FBP_W-1:0]       rt_fbp;
    logic signed [FBP_W-1:0]       l_fbr;
    logic signed [FBP_W-1:0]       rt_fbr;
    logic signed [ACC_W-1:0]       l_store_sum;
    logic signed [ACC_W-1:0]       rt_store_sum;
    logic signed [SAMPLE_BITS-1:0] n_left_store;
    logic signed [SAMPLE_BITS-1:0] n_right_store;

    logic signed [MIX_W-1:0] wet_s;
    logic signed [MIX_W-1:0] dry_s;
    logic signed [MIX_W-1:0] l_mix;
    logic signed [MIX_W-1:0] rt_mix;
    t_frame                  n_out;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_enable   <= 1'b0;
            r_delay_length  <= DELAY_W'(DELAY_RESET);
            r_feedback_gain <= '0;
            r_wet_mix       <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ECHO_ENABLE:   r_echo_enable   <= pwdata[0];
                REG_DELAY_LENGTH:  r_delay_length  <= pwdata[DELAY_W-1:0];
                REG_FEEDBACK_GAIN: r_feedback_gain <= pwdata[FB_W-1:0];
                REG_WET_MIX:       r_wet_mix       <= pwdata[WET_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ECHO_ENABLE:   prdata = PDATA_W'(r_echo_enable);
            REG_DELAY_LENGTH:  prdata = PDATA_W'(r_delay_length);
            REG_FEEDBACK_GAIN: prdata = PDATA_W'(r_feedback_gain);
            REG_WET_MIX:       prdata = PDATA_W'(r_wet_mix);
        endcase
    end

    // clamped settings
    always_comb begin
        if (r_delay_length == '0) begin
            d_cl = ADDR_W'(1);
        end else if (32'(r_delay_length) > STORE_DEPTH - 1) begin
            d_cl = ADDR_W'(STORE_DEPTH - 1);
        end else begin
            d_cl = ADDR_W'(r_delay_length);
        end
        fb_cl   = (r_feedback_gain > FB_W'(FB_MAX)) ? FB_W'(FB_MAX) : r_feedback_gain;
        wet_cl  = (r_wet_mix > WET_W'(WET_FULL)) ? WET_W'(WET_FULL) : r_wet_mix;
        wet_eff = r_echo_enable ? wet_cl : '0;
        dry_eff = WET_W'(WET_FULL) - wet_eff;
    end

    // input handshake with credit against the output queue
    assign credit = r_fifo_count + (FIFO_AW+1)'(r_a_valid) + (FIFO_AW+1)'(r_b_valid)
                    + (FIFO_AW+1)'(r_c_valid);
    assign i_frame.ready = i_rst_n && (credit < (FIFO_AW+1)'(FIFO_DEPTH));
    assign in_fire       = i_frame.valid && i_frame.ready;

    assign rd_addr = r_wp - d_cl;
    assign rd_zero = !r_wrapped && (rd_addr >= r_wp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
        end else if (in_fire && r_echo_enable) begin
            r_wp <= r_wp + ADDR_W'(1);
            if (r_wp == ADDR_W'(STORE_DEPTH - 1)) begin
                r_wrapped <= 1'b1;
            end
        end
    end

    // store read
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_left  <= mem_left[rd_addr];
            r_rd_right <= mem_right[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= in_fire;
        end
        if (in_fire) begin
            r_a_left  <= i_frame.left_in;
            r_a_right <= i_frame.right_in;
            r_a_rd    <= rd_addr;
            r_a_wp    <= r_wp;
            r_a_zero  <= rd_zero;
        end
    end

    // feedback and write-back
    assign a_fwd       = r_fwd_valid && (r_fwd_addr == r_a_rd);
    assign a_left_dly  = r_a_zero ? '0 : (a_fwd ? r_fwd_left : r_rd_left);
    assign a_right_dly = r_a_zero ? '0 : (a_fwd ? r_fwd_right : r_rd_right);

    assign fb_s   = FBP_W'(fb_cl);
    assign l_fbp  = FBP_W'(a_left_dly) * fb_s;
    assign rt_fbp = FBP_W'(a_right_dly) * fb_s;
    assign l_fbr  = l_fbp + FBP_W'(RND_HALF);
    assign rt_fbr = rt_fbp + FBP_W'(RND_HALF);

    assign l_store_sum  = ACC_W'(r_a_left)
                          + ACC_W'($signed(l_fbr[FBP_W-1:FRAC_BITS]));
    assign rt_store_sum = ACC_W'(r_a_right)
                          + ACC_W'($signed(rt_fbr[FBP_W-1:FRAC_BITS]));
    assign n_left_store  = sat_sample(l_store_sum);
    assign n_right_store = sat_sample(rt_store_sum);

    always_ff @(posedge i_clk) begin
        if (r_a_valid && r_echo_enable) begin
            mem_left[r_a_wp]  <= n_left_store;
            mem_right[r_a_wp] <= n_right_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= r_a_valid && r_echo_enable;
        end
        r_fwd_addr  <= r_a_wp;
        r_fwd_left  <= n_left_store;
        r_fwd_right <= n_right_store;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_left_in   <= r_a_left;
        r_b_right_in  <= r_a_right;
        r_b_left_dly  <= a_left_dly;
        r_b_right_dly <= a_right_dly;
    end

    // wet/dry products
    assign wet_s = MIX_W'(wet_eff);
    assign dry_s = MIX_W'(dry_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
        r_c_left_dry  <= MIX_W'(r_b_left_in) * dry_s;
        r_c_left_wet  <= MIX_W'(r_b_left_dly) * wet_s;
        r_c_right_dry <= MIX_W'(r_b_right_in) * dry_s;
        r_c_right_wet <= MIX_W'(r_b_right_dly) * wet_s;
    end

    assign l_mix  = r_c_left_dry + r_c_left_wet + MIX_W'(RND_HALF);
    assign rt_mix = r_c_right_dry + r_c_right_wet + MIX_W'(RND_HALF);
    assign n_out.left  = sat_sample(ACC_W'($signed(l_mix[MIX_W-1:FRAC_BITS])));
    assign n_out.right = sat_sample(ACC_W'($signed(rt_mix[MIX_W-1:FRAC_BITS])));

    // output queue
    assign out_fire           = o_frame.valid && o_frame.ready;
    assign o_frame.valid      = (r_fifo_count != '0);
    assign o_frame.left_out   = r_fifo[r_rd_ptr].left;
    assign o_frame.right_out  = r_fifo[r_rd_ptr].right;

    always_ff @(posedge i_clk) begin
        if (r_c_valid) begin
            r_fifo[r_wr_ptr] <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_fifo_count <= '0;
        end else begin
            if (r_c_valid) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (r_c_valid && !out_fire) begin
                r_fifo_count <= r_fifo_count + (FIFO_AW+1)'(1);
            end else if (!r_c_valid && out_fire) begin
                r_fifo_count <= r_fifo_count - (FIFO_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire
